FILE: src/mvt_pkg.sv
// ----------------------------------------------------------------------------
// mvt_pkg
// Types, op codes and helpers shared by the matrix-vector transform block.
// ----------------------------------------------------------------------------
package mvt_pkg;

  typedef enum logic [2:0] {
    OP_LOAD      = 3'd0,
    OP_MXV       = 3'd1,
    OP_VXM       = 3'd2,
    OP_SCALE     = 3'd3,
    OP_TRANSLATE = 3'd4,
    OP_TRANSPOSE = 3'd5
  } op_t;

  typedef struct packed {
    logic        [2:0]  op;
    logic        [3:0]  elem_index;
    logic signed [31:0] in_x;
    logic signed [31:0] in_y;
    logic signed [31:0] in_z;
    logic signed [31:0] in_w;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] out_x;
    logic signed [31:0] out_y;
    logic signed [31:0] out_z;
    logic signed [31:0] out_w;
  } out_item_t;

  // Decoded command as it waits in the queue.
  typedef struct packed {
    op_t                op;
    logic        [3:0]  idx;
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
    logic signed [31:0] w;
  } cmd_t;

  localparam int ACC_W = 68;

  function automatic logic signed [31:0] sat32(input logic signed [ACC_W-1:0] v);
    logic signed [ACC_W-1:0] hi;
    logic signed [ACC_W-1:0] lo;
    hi = ACC_W'(64'sd2147483647);
    lo = -ACC_W'(64'sd2147483648);
    if (v > hi) begin
      sat32 = 32'sh7fffffff;
    end else if (v < lo) begin
      sat32 = 32'sh80000000;
    end else begin
      sat32 = v[31:0];
    end
  endfunction

endpackage

FILE: src/mvt_front.sv
// ----------------------------------------------------------------------------
// mvt_front
// Accepts input beats, decodes the op and drops unused op codes.
// ----------------------------------------------------------------------------
module mvt_front
  import mvt_pkg::*;
(
  input  logic     in_valid,
  output logic     in_ready,
  input  in_item_t in_data,
  output logic     cmd_valid,
  input  logic     cmd_ready,
  output cmd_t     cmd
);

  logic known;

  always_comb begin
    known = 1'b1;
    cmd.op = OP_LOAD;
    unique case (in_data.op)
      OP_LOAD:      cmd.op = OP_LOAD;
      OP_MXV:       cmd.op = OP_MXV;
      OP_VXM:       cmd.op = OP_VXM;
      OP_SCALE:     cmd.op = OP_SCALE;
      OP_TRANSLATE: cmd.op = OP_TRANSLATE;
      OP_TRANSPOSE: cmd.op = OP_TRANSPOSE;
      default:      known = 1'b0;
    endcase
    cmd.idx = in_data.elem_index;
    cmd.x   = in_data.in_x;
    cmd.y   = in_data.in_y;
    cmd.z   = in_data.in_z;
    cmd.w   = in_data.in_w;
  end

  // Unused codes are taken and discarded without touching the queue.
  assign in_ready  = cmd_ready;
  assign cmd_valid = in_valid && known;

endmodule

FILE: src/mvt_queue.sv
// ----------------------------------------------------------------------------
// mvt_queue
// Two-entry command queue between the decode and execute sides.
// ----------------------------------------------------------------------------
module mvt_queue
  import mvt_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic wr_valid,
  output logic wr_ready,
  input  cmd_t wr_data,
  output logic rd_valid,
  input  logic rd_ready,
  output cmd_t rd_data
);

  cmd_t       mem_r [2];
  logic       wr_ptr_r;
  logic       rd_ptr_r;
  logic [1:0] count_r;
  logic       push;
  logic       pop;

  assign wr_ready = (count_r != 2'd2);
  assign rd_valid = (count_r != 2'd0);
  assign rd_data  = mem_r[rd_ptr_r];
  assign push     = wr_valid && wr_ready;
  assign pop      = rd_valid && rd_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (push) wr_ptr_r <= ~wr_ptr_r;
      if (pop) rd_ptr_r <= ~rd_ptr_r;
      count_r <= count_r + 2'(push) - 2'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wr_ptr_r] <= wr_data;
  end

endmodule

FILE: src/mvt_back.sv
// ----------------------------------------------------------------------------
// mvt_back
// Holds the matrix and executes commands: a multiply stage of sixteen
// products, then a sum, shift and saturate stage feeding the output register.
// ----------------------------------------------------------------------------
module mvt_back
  import mvt_pkg::*;
#(
  parameter int FRAC_BITS = 16
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      cmd_valid,
  output logic      cmd_ready,
  input  cmd_t      cmd,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data
);

  logic signed [31:0]      mat_r   [16];
  logic signed [31:0]      mat_nxt [16];
  logic signed [63:0]      prod_r  [16];
  logic signed [63:0]      prod_nxt[16];
  logic signed [ACC_W-1:0] sh      [4];
  logic signed [31:0]      res     [4];
  logic signed [31:0]      vec     [4];
  logic                    s2_vld_r;
  op_t                     s2_op_r;
  logic                    out_vld_r;
  out_item_t               out_data_r;
  logic                    adv;
  logic                    s2_mod;
  logic                    issue;

  assign adv       = !out_vld_r || out_ready;
  // A scale or translate writes the matrix from the second stage, so nothing
  // issues behind it until that write has landed.
  assign s2_mod    = s2_vld_r && (s2_op_r == OP_SCALE || s2_op_r == OP_TRANSLATE);
  assign cmd_ready = adv && !s2_mod;
  assign issue     = cmd_valid && cmd_ready;

  always_comb begin
    logic signed [31:0] a;
    logic signed [31:0] b;
    vec[0] = cmd.x;
    vec[1] = cmd.y;
    vec[2] = cmd.z;
    vec[3] = (cmd.op == OP_TRANSLATE) ? 32'sd0 : cmd.w;
    for (int i = 0; i < 4; i++) begin
      for (int j = 0; j < 4; j++) begin
        if (cmd.op == OP_VXM) begin
          a = mat_r[j*4+i];
        end else begin
          a = mat_r[i*4+j];
        end
        b = vec[j];
        prod_nxt[i*4+j] = 64'(a) * 64'(b);
      end
    end
  end

  always_comb begin
    logic signed [ACC_W-1:0] sum;
    for (int i = 0; i < 4; i++) begin
      sum = ACC_W'(prod_r[i*4]) + ACC_W'(prod_r[i*4+1])
          + ACC_W'(prod_r[i*4+2]) + ACC_W'(prod_r[i*4+3]);
      sh[i]  = sum >>> FRAC_BITS;
      res[i] = sat32(sh[i]);
    end
  end

  always_comb begin
    for (int k = 0; k < 16; k++) mat_nxt[k] = mat_r[k];
    if (issue) begin
      if (cmd.op == OP_LOAD) begin
        mat_nxt[cmd.idx] = cmd.x;
      end else if (cmd.op == OP_TRANSPOSE) begin
        for (int i = 0; i < 4; i++) begin
          for (int j = 0; j < 4; j++) mat_nxt[i*4+j] = mat_r[j*4+i];
        end
      end
    end
    if (s2_vld_r && adv) begin
      if (s2_op_r == OP_SCALE) begin
        for (int i = 0; i < 4; i++) begin
          for (int j = 0; j < 3; j++) begin
            mat_nxt[i*4+j] = sat32(ACC_W'(prod_r[i*4+j]) >>> FRAC_BITS);
          end
        end
      end else if (s2_op_r == OP_TRANSLATE) begin
        for (int i = 0; i < 4; i++) begin
          mat_nxt[i*4+3] = sat32(ACC_W'(mat_r[i*4+3]) + sh[i]);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < 16; k++) begin
        mat_r[k] <= (k % 5 == 0) ? (32'sd1 <<< FRAC_BITS) : 32'sd0;
      end
      s2_vld_r  <= 1'b0;
      s2_op_r   <= OP_LOAD;
      out_vld_r <= 1'b0;
    end else begin
      for (int k = 0; k < 16; k++) mat_r[k] <= mat_nxt[k];
      if (adv) begin
        s2_vld_r  <= issue;
        s2_op_r   <= cmd.op;
        out_vld_r <= s2_vld_r && (s2_op_r == OP_MXV || s2_op_r == OP_VXM);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      for (int k = 0; k < 16; k++) prod_r[k] <= prod_nxt[k];
    end
    if (adv) begin
      out_data_r.out_x <= res[0];
      out_data_r.out_y <= res[1];
      out_data_r.out_z <= res[2];
      out_data_r.out_w <= res[3];
    end
  end

  assign out_valid = out_vld_r;
  assign out_data  = out_data_r;

endmodule

FILE: src/matrix_vector_transform.sv
// ----------------------------------------------------------------------------
// matrix_vector_transform
// 4x4 Q16.16 matrix unit: element load, M*v, v*M, scale, translate, transpose.
// ----------------------------------------------------------------------------
//   Channel  Direction  Payload     Handshake
//   in_      input      in_item_t   in_valid / in_ready
//   out_     output     out_item_t  out_valid / out_ready
//
// One beat per cycle for loads, transforms and transposes while out_ready does
// not hold the output; a scale or translate blocks the next command until its
// matrix update is written by the second stage. A transform's out_valid rises
// once it has passed the queue, product and output registers. A two-entry queue
// separates decode from execution, so up to two more input beats are taken
// while a result waits on out_ready. Reset restores the identity matrix.
// ----------------------------------------------------------------------------
module matrix_vector_transform
  import mvt_pkg::*;
#(
  parameter int FRAC_BITS = 16
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data
);

  logic fq_valid;
  logic fq_ready;
  cmd_t fq_cmd;
  logic qb_valid;
  logic qb_ready;
  cmd_t qb_cmd;

  mvt_front u_front (
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .cmd_valid (fq_valid),
    .cmd_ready (fq_ready),
    .cmd       (fq_cmd)
  );

  mvt_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_valid (fq_valid),
    .wr_ready (fq_ready),
    .wr_data  (fq_cmd),
    .rd_valid (qb_valid),
    .rd_ready (qb_ready),
    .rd_data  (qb_cmd)
  );

  mvt_back #(
    .FRAC_BITS (FRAC_BITS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (qb_valid),
    .cmd_ready (qb_ready),
    .cmd       (qb_cmd),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule
